// ----- rtl/core/vfm_pkg.sv -----
// Package for the voxel face mesher: widths, result kinds, side codes,
// controller states, command/status structs and the side-to-corner table.
// No dependencies.
`default_nettype none

package vfm_pkg;

    localparam int DEFAULT_GRID_SIDE = 32;
    localparam int POS_W             = 5;
    localparam int VCOORD_W          = 6;
    localparam int IDX_W             = 16;
    localparam int NUM_SIDES         = 6;
    localparam int NUM_CORNERS       = 8;

    localparam logic KIND_VERT = 1'b0;
    localparam logic KIND_TRI  = 1'b1;

    localparam logic [2:0] SIDE_XM = 3'd0;
    localparam logic [2:0] SIDE_XP = 3'd1;
    localparam logic [2:0] SIDE_ZM = 3'd2;
    localparam logic [2:0] SIDE_ZP = 3'd3;
    localparam logic [2:0] SIDE_YM = 3'd4;
    localparam logic [2:0] SIDE_YP = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SIDE,
        ST_CORNER,
        ST_LOOK,
        ST_TRI0,
        ST_TRI1
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic side_start;
        logic rd_issue;
        logic use_cache;
        logic use_seen;
        logic new_vert;
        logic emit_tri0;
        logic emit_tri1;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic mask_empty;
        logic have_cur;
        logic rd_seen;
        logic j_last;
        logic out_free;
    } t_dp_sts;

    // corner number: bit 2 x offset, bit 1 z offset, bit 0 y offset
    function automatic logic [2:0] quad_corner(input logic [2:0] side, input logic [1:0] pos);
        logic [3:0][2:0] row;
        case (side)
            SIDE_XM: row = {3'd2, 3'd3, 3'd1, 3'd0};
            SIDE_XP: row = {3'd4, 3'd5, 3'd7, 3'd6};
            SIDE_ZM: row = {3'd1, 3'd5, 3'd4, 3'd0};
            SIDE_ZP: row = {3'd6, 3'd7, 3'd3, 3'd2};
            SIDE_YM: row = {3'd6, 3'd2, 3'd0, 3'd4};
            SIDE_YP: row = {3'd3, 3'd7, 3'd5, 3'd1};
            default: row = '0;
        endcase
        return row[pos];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vfm_vox_if.sv -----
// Voxel input channel: valid/ready handshake and voxel payload.
// Depends on vfm_pkg.
`default_nettype none

interface vfm_vox_if import vfm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    pos_z;
    logic                occupied;
    logic                nbr_x_minus;
    logic                nbr_x_plus;
    logic                nbr_z_minus;
    logic                nbr_z_plus;
    logic                nbr_y_minus;
    logic                nbr_y_plus;

    modport source (
        output valid, pos_x, pos_y, pos_z, occupied,
               nbr_x_minus, nbr_x_plus, nbr_z_minus, nbr_z_plus, nbr_y_minus, nbr_y_plus,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, occupied,
               nbr_x_minus, nbr_x_plus, nbr_z_minus, nbr_z_plus, nbr_y_minus, nbr_y_plus,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/vfm_res_if.sv -----
// Result output channel: valid/ready handshake and vertex/triangle payload.
// Depends on vfm_pkg.
`default_nettype none

interface vfm_res_if import vfm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [VCOORD_W-1:0] vert_x;
    logic [VCOORD_W-1:0] vert_y;
    logic [VCOORD_W-1:0] vert_z;
    logic [IDX_W-1:0]    vert_id;
    logic [IDX_W-1:0]    tri_a;
    logic [IDX_W-1:0]    tri_b;
    logic [IDX_W-1:0]    tri_c;
    logic                last;

    modport source (
        output valid, kind, vert_x, vert_y, vert_z, vert_id, tri_a, tri_b, tri_c, last,
        input  ready
    );

    modport sink (
        input  valid, kind, vert_x, vert_y, vert_z, vert_id, tri_a, tri_b, tri_c, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/vfm_ctrl.sv -----
// Controller state machine: clearing pass, voxel accept, side and corner
// sequencing, result emission. Depends on vfm_pkg.
`default_nettype none

module vfm_ctrl import vfm_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SIDE;
            end
            ST_SIDE: begin
                n_state = i_sts.mask_empty ? ST_IDLE : ST_CORNER;
            end
            ST_CORNER: begin
                if (i_sts.have_cur) begin
                    n_state = i_sts.j_last ? ST_TRI0 : ST_CORNER;
                end else begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (i_sts.rd_seen || i_sts.out_free) begin
                    n_state = i_sts.j_last ? ST_TRI0 : ST_CORNER;
                end
            end
            ST_TRI0: begin
                if (i_sts.out_free) n_state = ST_TRI1;
            end
            ST_TRI1: begin
                if (i_sts.out_free) n_state = i_sts.mask_empty ? ST_IDLE : ST_SIDE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: o_cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SIDE: o_cmd.side_start = !i_sts.mask_empty;
            ST_CORNER: begin
                o_cmd.use_cache = i_sts.have_cur;
                o_cmd.rd_issue  = !i_sts.have_cur;
            end
            ST_LOOK: begin
                o_cmd.use_seen = i_sts.rd_seen;
                o_cmd.new_vert = !i_sts.rd_seen && i_sts.out_free;
            end
            ST_TRI0: o_cmd.emit_tri0 = i_sts.out_free;
            ST_TRI1: o_cmd.emit_tri1 = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/vfm_datapath.sv -----
// Datapath: voxel registers, exposed-side mask, corner cache, corner table
// memory, vertex counter and result register. Depends on vfm_pkg.
`default_nettype none

module vfm_datapath import vfm_pkg::*; #(
    parameter int GRID_SIDE = DEFAULT_GRID_SIDE
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [POS_W-1:0]    i_pos_x,
    input  wire logic [POS_W-1:0]    i_pos_y,
    input  wire logic [POS_W-1:0]    i_pos_z,
    input  wire logic                i_occupied,
    input  wire logic [NUM_SIDES-1:0] i_nbr,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_kind,
    output logic [VCOORD_W-1:0]      o_vert_x,
    output logic [VCOORD_W-1:0]      o_vert_y,
    output logic [VCOORD_W-1:0]      o_vert_z,
    output logic [IDX_W-1:0]         o_vert_id,
    output logic [IDX_W-1:0]         o_tri_a,
    output logic [IDX_W-1:0]         o_tri_b,
    output logic [IDX_W-1:0]         o_tri_c,
    output logic                     o_last
);

    localparam int CS    = GRID_SIDE + 1;
    localparam int DEPTH = CS * CS * CS;
    localparam int AW    = $clog2(DEPTH);
    localparam int GW    = POS_W + 2;

    logic [POS_W-1:0]       r_px, r_py, r_pz;
    logic [NUM_SIDES-1:0]   r_mask;
    logic [2:0]             r_side;
    logic [1:0]             r_j;
    logic [NUM_CORNERS-1:0] r_have;
    logic [IDX_W-1:0]       r_idx [NUM_CORNERS];
    logic [IDX_W-1:0]       r_q [4];
    logic [IDX_W-1:0]       r_next;
    logic [AW-1:0]          r_addr;
    logic [AW-1:0]          r_clr_cnt;
    logic                   r_rd_seen;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [IDX_W:0]         r_mem [DEPTH];

    logic                   r_out_valid;
    logic                   r_kind;
    logic [VCOORD_W-1:0]    r_vert_x, r_vert_y, r_vert_z;
    logic [IDX_W-1:0]       r_vert_id;
    logic [IDX_W-1:0]       r_tri_a, r_tri_b, r_tri_c;
    logic                   r_last;

    logic [2:0]             n_first;
    logic [2:0]             cur_c;
    logic [VCOORD_W-1:0]    cx, cy, cz;
    logic [AW-1:0]          n_addr;
    logic [NUM_SIDES-1:0]   n_exposed;
    logic                   in_grid;
    logic                   out_free;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [IDX_W:0]         mem_wdata;
    logic [GW-1:0]          ext_x, ext_y, ext_z;

    assign ext_x = GW'(i_pos_x);
    assign ext_y = GW'(i_pos_y);
    assign ext_z = GW'(i_pos_z);

    assign in_grid = (ext_x < GW'(GRID_SIDE)) && (ext_y < GW'(GRID_SIDE))
                  && (ext_z < GW'(GRID_SIDE));

    always_comb begin
        n_exposed[SIDE_XM] = (i_pos_x == '0) || !i_nbr[SIDE_XM];
        n_exposed[SIDE_XP] = (ext_x + GW'(1) >= GW'(GRID_SIDE)) || !i_nbr[SIDE_XP];
        n_exposed[SIDE_ZM] = (i_pos_z == '0) || !i_nbr[SIDE_ZM];
        n_exposed[SIDE_ZP] = (ext_z + GW'(1) >= GW'(GRID_SIDE)) || !i_nbr[SIDE_ZP];
        n_exposed[SIDE_YM] = (i_pos_y == '0) || !i_nbr[SIDE_YM];
        n_exposed[SIDE_YP] = (ext_y + GW'(1) >= GW'(GRID_SIDE)) || !i_nbr[SIDE_YP];
    end

    always_comb begin
        n_first = 3'd0;
        for (int k = NUM_SIDES - 1; k >= 0; k--) begin
            if (r_mask[k]) n_first = 3'(k);
        end
    end

    assign cur_c  = quad_corner(r_side, r_j);
    assign cx     = VCOORD_W'(r_px) + VCOORD_W'(cur_c[2]);
    assign cy     = VCOORD_W'(r_py) + VCOORD_W'(cur_c[0]);
    assign cz     = VCOORD_W'(r_pz) + VCOORD_W'(cur_c[1]);
    assign n_addr = AW'(cx) + AW'(CS) * AW'(cy) + AW'(CS * CS) * AW'(cz);

    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.clr_last   = (r_clr_cnt == AW'(DEPTH - 1));
    assign o_sts.mask_empty = (r_mask == '0);
    assign o_sts.have_cur   = r_have[cur_c];
    assign o_sts.rd_seen    = r_rd_seen;
    assign o_sts.j_last     = (r_j == 2'd3);
    assign o_sts.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_next    <= '0;
            r_mask    <= '0;
            r_have    <= '0;
            r_j       <= '0;
        end else begin
            if (i_cmd.clr_wr && !o_sts.clr_last) r_clr_cnt <= r_clr_cnt + AW'(1);
            if (i_cmd.load) begin
                r_mask <= (i_occupied && in_grid) ? n_exposed : '0;
                r_have <= '0;
            end
            if (i_cmd.side_start) begin
                r_mask <= r_mask & ~(NUM_SIDES'(1) << n_first);
                r_j    <= '0;
            end
            if (i_cmd.use_cache || i_cmd.use_seen || i_cmd.new_vert) r_j <= r_j + 2'd1;
            if (i_cmd.use_seen || i_cmd.new_vert) r_have[cur_c] <= 1'b1;
            if (i_cmd.new_vert) r_next <= r_next + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
        end
        if (i_cmd.side_start) r_side <= n_first;
        if (i_cmd.rd_issue) r_addr <= n_addr;
        if (i_cmd.use_cache) r_q[r_j] <= r_idx[cur_c];
        if (i_cmd.use_seen) begin
            r_q[r_j]     <= r_rd_idx;
            r_idx[cur_c] <= r_rd_idx;
        end
        if (i_cmd.new_vert) begin
            r_q[r_j]     <= r_next;
            r_idx[cur_c] <= r_next;
        end
    end

    assign mem_we    = i_cmd.clr_wr || i_cmd.new_vert;
    assign mem_waddr = i_cmd.clr_wr ? r_clr_cnt : r_addr;
    assign mem_wdata = i_cmd.clr_wr ? '0 : {1'b1, r_next};

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_cmd.rd_issue) {r_rd_seen, r_rd_idx} <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.new_vert || i_cmd.emit_tri0 || i_cmd.emit_tri1) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.new_vert) begin
            r_kind    <= KIND_VERT;
            r_vert_x  <= cx;
            r_vert_y  <= cy;
            r_vert_z  <= cz;
            r_vert_id <= r_next;
            r_tri_a   <= '0;
            r_tri_b   <= '0;
            r_tri_c   <= '0;
            r_last    <= 1'b0;
        end else if (i_cmd.emit_tri0 || i_cmd.emit_tri1) begin
            r_kind    <= KIND_TRI;
            r_vert_x  <= '0;
            r_vert_y  <= '0;
            r_vert_z  <= '0;
            r_vert_id <= '0;
            r_tri_a   <= i_cmd.emit_tri0 ? r_q[0] : r_q[2];
            r_tri_b   <= i_cmd.emit_tri0 ? r_q[1] : r_q[3];
            r_tri_c   <= i_cmd.emit_tri0 ? r_q[2] : r_q[0];
            r_last    <= i_cmd.emit_tri1 && (r_mask == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_vert_x    = r_vert_x;
    assign o_vert_y    = r_vert_y;
    assign o_vert_z    = r_vert_z;
    assign o_vert_id   = r_vert_id;
    assign o_tri_a     = r_tri_a;
    assign o_tri_b     = r_tri_b;
    assign o_tri_c     = r_tri_c;
    assign o_last      = r_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.new_vert || i_cmd.emit_tri0 || i_cmd.emit_tri1) |-> out_free)
        else $error("result emitted while output register holds an item");

    a_next_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.new_vert |=> (r_next == $past(r_next) + IDX_W'(1)))
        else $error("vertex counter did not advance on new vertex");

    a_last_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_kind == KIND_TRI))
        else $error("last flag on a vertex item");

    a_seen_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.use_seen |-> $past(i_cmd.rd_issue))
        else $error("table hit taken without a preceding read");

endmodule

`default_nettype wire

// ----- rtl/core/voxel_face_mesher_core.sv -----
// Top level of the voxel face mesher: joins the controller and datapath to
// the voxel and result channels. Depends on vfm_pkg, vfm_vox_if, vfm_res_if,
// vfm_ctrl and vfm_datapath.
//
// Usage: i_vox carries one voxel per item (coordinate, solid flag, six
// neighbor flags); o_res carries vertex and triangle items, last set on the
// final item of a voxel. Both use valid/ready; an item moves when both are high.
// After reset the corner table is cleared, one entry per cycle, for all
// (GRID_SIDE+1)^3 entries (35937 at the default); i_vox.ready stays low until
// the pass completes.
// One voxel is worked on at a time. An empty, out-of-grid or enclosed voxel
// is accepted and passes the side step with no result. Otherwise a voxel is
// accepted, then for each exposed side there is a side step, a cache step per
// corner already known in this voxel, a read and a look step per corner looked
// up in the table, and a step per triangle. The output register takes one
// result per cycle while the receiver is ready.
// A stalled receiver holds the output register and the sequencer waits; a new
// voxel is taken while the last result of the previous one still waits.
`default_nettype none

module voxel_face_mesher_core import vfm_pkg::*; #(
    parameter int GRID_SIDE = DEFAULT_GRID_SIDE
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vfm_vox_if.sink    i_vox,
    vfm_res_if.source  o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_vox.ready = in_ready;

    vfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vox.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vfm_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pos_x     (i_vox.pos_x),
        .i_pos_y     (i_vox.pos_y),
        .i_pos_z     (i_vox.pos_z),
        .i_occupied  (i_vox.occupied),
        .i_nbr       ({i_vox.nbr_y_plus, i_vox.nbr_y_minus, i_vox.nbr_z_plus,
                       i_vox.nbr_z_minus, i_vox.nbr_x_plus, i_vox.nbr_x_minus}),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_kind      (o_res.kind),
        .o_vert_x    (o_res.vert_x),
        .o_vert_y    (o_res.vert_y),
        .o_vert_z    (o_res.vert_z),
        .o_vert_id   (o_res.vert_id),
        .o_tri_a     (o_res.tri_a),
        .o_tri_b     (o_res.tri_b),
        .o_tri_c     (o_res.tri_c),
        .o_last      (o_res.last)
    );

endmodule

`default_nettype wire
